// File: src/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock outside reset
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: src/dtls_pkg.sv
// package with types, constants and helpers of the decimal line summer
`timescale 1ns / 1ps
`default_nettype none
package dtls_pkg;
  localparam int LineLimit = 99;
  localparam int MantissaDigits = 18;
  localparam int FractionBits = 16;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic signed [63:0] running_total;
    logic               saturated;
  } out_t;

  localparam logic [2:0] PH_SPACE = 3'd0;
  localparam logic [2:0] PH_INT = 3'd1;
  localparam logic [2:0] PH_FRAC = 3'd2;
  localparam logic [2:0] PH_ESIGN = 3'd3;
  localparam logic [2:0] PH_EXP = 3'd4;
  localparam logic [2:0] PH_DONE = 3'd5;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_LOWER_E = 8'h65;
  localparam logic [7:0] CH_UPPER_E = 8'h45;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // commands from controller to datapath
  typedef struct packed {
    logic parse;
    logic scale_start;
    logic scale_step;
    logic finish;
  } cmd_t;

  // status back to the controller
  typedef struct packed {
    logic chunk_end;
    logic chunk_empty;
    logic scale_done;
  } sts_t;

  function automatic logic [59:0] mant_max(input int digits);
    logic [59:0] m;
    m = 60'd1;
    for (int i = 0; i < 18; i++) begin
      if (i < digits) m = m * 60'd10;
    end
    return m - 60'd1;
  endfunction
endpackage
`default_nettype wire

// File: src/dtls_datapath.sv
// datapath: byte parser, scaling loop and saturating accumulator
`timescale 1ns / 1ps
`default_nettype none
module dtls_datapath #(
  parameter int LINE_LIMIT = dtls_pkg::LineLimit,
  parameter int MANTISSA_DIGITS = dtls_pkg::MantissaDigits,
  parameter int FRACTION_BITS = dtls_pkg::FractionBits
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [7:0]    ch,
  input  wire dtls_pkg::cmd_t cmd,
  output dtls_pkg::sts_t     sts,
  output dtls_pkg::out_t     result
);
  localparam logic [59:0] MantMax = dtls_pkg::mant_max(MANTISSA_DIGITS);
  localparam logic [63:0] PosLimit = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NegLimit = 64'h8000_0000_0000_0000;
  localparam logic [63:0] PosLimitDiv10 = PosLimit / 64'd10;
  localparam logic [63:0] NegLimitDiv10 = NegLimit / 64'd10;
  localparam int LenW = $clog2(LINE_LIMIT + 1);
  localparam int MagW = 68 + FRACTION_BITS;

  logic [2:0]  phase;
  logic [59:0] mantissa;
  logic [4:0]  frac_cnt;
  logic [6:0]  exp_val;
  logic        exp_neg;
  logic        val_neg;
  logic [LenW-1:0] chunk_len;
  logic        chunk_sat;
  logic signed [63:0] sum;

  // scaling loop registers
  logic [MagW-1:0] mag;
  logic [7:0]   steps;
  logic         up;
  logic         ov;
  // divide by ten: shift-add quotient estimate refined in steps counted by dsub
  logic [MagW-1:0] dq;
  logic [2:0]   dsub;

  logic [2:0]  phase_next;
  logic [59:0] mant_next;
  logic [4:0]  frac_next;
  logic [6:0]  exp_next;
  logic        exp_neg_next, val_neg_next, sat_next;
  logic        is_dig, is_sp, is_e;
  logic [3:0]  dig;
  logic [63:0] mant_x10;
  logic [10:0] exp_tmp;
  logic [2:0]  ph;

  always_comb begin
    is_dig = (ch >= dtls_pkg::CH_ZERO) && (ch <= dtls_pkg::CH_NINE);
    is_sp = (ch == 8'h20) || (ch >= 8'h09 && ch <= 8'h0D);
    is_e = (ch == dtls_pkg::CH_LOWER_E) || (ch == dtls_pkg::CH_UPPER_E);
    dig = 4'(ch - dtls_pkg::CH_ZERO);
    mant_x10 = (64'(mantissa) << 3) + (64'(mantissa) << 1) + 64'(dig);
    exp_tmp = 11'(exp_val) * 11'd10 + 11'(dig);
    phase_next = phase;
    mant_next = mantissa;
    frac_next = frac_cnt;
    exp_next = exp_val;
    exp_neg_next = exp_neg;
    val_neg_next = val_neg;
    sat_next = chunk_sat;
    ph = phase;
    if (ph == dtls_pkg::PH_SPACE) begin
      if (is_sp) ph = dtls_pkg::PH_DONE + 3'd1;
      else if (ch == dtls_pkg::CH_MINUS) begin
        val_neg_next = 1'b1;
        phase_next = dtls_pkg::PH_INT;
        ph = dtls_pkg::PH_DONE + 3'd1;
      end else if (ch == dtls_pkg::CH_PLUS) begin
        phase_next = dtls_pkg::PH_INT;
        ph = dtls_pkg::PH_DONE + 3'd1;
      end else ph = dtls_pkg::PH_INT;
    end
    if (ph == dtls_pkg::PH_ESIGN) begin
      phase_next = dtls_pkg::PH_EXP;
      if (ch == dtls_pkg::CH_MINUS) begin
        exp_neg_next = 1'b1;
        ph = dtls_pkg::PH_DONE + 3'd1;
      end else if (ch == dtls_pkg::CH_PLUS) ph = dtls_pkg::PH_DONE + 3'd1;
      else ph = dtls_pkg::PH_EXP;
    end
    case (ph)
      dtls_pkg::PH_INT, dtls_pkg::PH_FRAC: begin
        if (is_dig) begin
          phase_next = ph;
          if (mant_x10 > 64'(MantMax)) begin
            mant_next = MantMax;
            sat_next = 1'b1;
          end else mant_next = mant_x10[59:0];
          if (ph == dtls_pkg::PH_FRAC) begin
            if (frac_cnt < 5'd31) frac_next = frac_cnt + 5'd1;
            else sat_next = 1'b1;
          end
        end else if (ph == dtls_pkg::PH_INT && ch == dtls_pkg::CH_POINT) begin
          phase_next = dtls_pkg::PH_FRAC;
        end else phase_next = is_e ? dtls_pkg::PH_ESIGN : dtls_pkg::PH_DONE;
      end
      dtls_pkg::PH_EXP: begin
        if (is_dig) exp_next = (exp_tmp > 11'd99) ? 7'd99 : exp_tmp[6:0];
        else phase_next = dtls_pkg::PH_DONE;
      end
      default: ;
    endcase
  end

  logic signed [8:0] scale_s;
  logic [63:0] lim;
  logic [63:0] lim_div10;
  logic [MagW-1:0] mag_x10;
  logic [MagW-1:0] dq_sh;
  logic [4:0]  q10_lo;
  logic [4:0]  rem5;
  logic [63:0] val;
  logic [63:0] sum_raw;
  logic        sum_ov;
  assign scale_s = (exp_neg ? -9'(exp_val) : 9'(exp_val)) - 9'(frac_cnt);
  assign lim = val_neg ? NegLimit : PosLimit;
  assign lim_div10 = val_neg ? NegLimitDiv10 : PosLimitDiv10;
  assign mag_x10 = (mag << 3) + (mag << 1);
  assign dq_sh = dq >> 3;
  assign q10_lo = {dq_sh[1:0], 3'b000} + {dq_sh[3:0], 1'b0};
  assign rem5 = mag[4:0] - q10_lo;

  always_comb begin
    logic [63:0] m;
    m = lim;
    if (!ov) m = mag[63:0];
    val = val_neg ? 64'(0) - m : m;
  end
  assign sum_raw = sum + val;
  assign sum_ov = (sum[63] == val[63]) && (sum_raw[63] != sum[63]);

  assign sts.chunk_end = (ch == dtls_pkg::CH_NEWLINE)
    || (32'(chunk_len) + 1 >= LINE_LIMIT);
  assign sts.chunk_empty = (chunk_len == '0);
  assign sts.scale_done = (steps == 8'd0) || ov || (!up && mag == '0);

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      phase <= dtls_pkg::PH_SPACE;
      mantissa <= '0;
      frac_cnt <= '0;
      exp_val <= '0;
      exp_neg <= 1'b0;
      val_neg <= 1'b0;
      chunk_len <= '0;
      chunk_sat <= 1'b0;
    end else if (cmd.parse) begin
      phase <= phase_next;
      mantissa <= mant_next;
      frac_cnt <= frac_next;
      exp_val <= exp_next;
      exp_neg <= exp_neg_next;
      val_neg <= val_neg_next;
      chunk_sat <= sat_next;
      chunk_len <= chunk_len + 1'b1;
    end
    if (rst) sum <= '0;
    else if (cmd.finish) begin
      sum <= sum_ov ? (sum[63] ? NegLimit : PosLimit) : sum_raw;
      result.running_total <= sum_ov ? (sum[63] ? NegLimit : PosLimit) : sum_raw;
      result.saturated <= chunk_sat || ov || sum_ov;
    end
    if (cmd.scale_start) begin
      up <= !scale_s[8];
      ov <= 1'b0;
      dsub <= 3'd0;
      if (!scale_s[8]) begin
        mag <= MagW'(mantissa);
        steps <= 8'(scale_s);
      end else begin
        mag <= MagW'(mantissa) << FRACTION_BITS;
        steps <= 8'(-scale_s);
      end
      if (mantissa == '0) steps <= 8'd0;
    end else if (cmd.scale_step) begin
      if (steps != 8'd0 && !ov) begin
        if (up) begin
          steps <= steps - 8'd1;
          if (mag[63:0] > lim_div10) ov <= 1'b1;
          else mag <= mag_x10;
        end else begin
          // quotient estimate is low by at most one, fixed by the remainder
          case (dsub)
            3'd0: dq <= (mag >> 1) + (mag >> 2);
            3'd1: dq <= dq + (dq >> 4);
            3'd2: dq <= dq + (dq >> 8);
            3'd3: dq <= dq + (dq >> 16);
            3'd4: dq <= dq + (dq >> 32);
            3'd5: dq <= dq + (dq >> 64);
            default: begin
              mag <= dq_sh + MagW'(rem5 > 5'd9);
              steps <= steps - 8'd1;
            end
          endcase
          dsub <= (dsub >= 3'd6) ? 3'd0 : dsub + 3'd1;
        end
      end else if (steps == 8'd0 && !ov) begin
        // final fixup: shift up or range check
        if (up) begin
          if (mag[63:0] > (lim >> FRACTION_BITS)) ov <= 1'b1;
          else mag <= mag << FRACTION_BITS;
          up <= 1'b0;
        end else if (mag > MagW'(lim)) ov <= 1'b1;
      end
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_frac_bound, 1'b1, frac_cnt <= 5'd31)
  `ASSERT_IMPL(a_exp_bound, 1'b1, exp_val <= 7'd99)
  `ASSERT_IMPL(a_mant_bound, 1'b1, mantissa <= MantMax)
  `ASSERT_NEXT(a_finish_clears, cmd.finish, chunk_len == '0)
endmodule
`default_nettype wire

// File: src/dtls_ctrl.sv
// controller state machine for the line summer
`timescale 1ns / 1ps
`default_nettype none
module dtls_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          eot,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire dtls_pkg::sts_t sts,
  output dtls_pkg::cmd_t     cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_SCALE = 3'd2;
  localparam logic [2:0] S_FIX = 3'd3;
  localparam logic [2:0] S_HALT = 3'd4;

  logic [2:0] state, state_next;
  logic       halt_after, halt_after_next;
  logic       out_valid_next;
  logic       acc;

  // once halted after end of text every request is taken and dropped
  assign in_stall = (state != S_IDLE) && (state != S_HALT);
  assign acc = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    halt_after_next = halt_after;
    out_valid_next = out_valid && out_stall;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (acc) begin
          if (eot) begin
            halt_after_next = 1'b1;
            state_next = sts.chunk_empty ? S_HALT : S_START;
          end else begin
            cmd.parse = 1'b1;
            if (sts.chunk_end) state_next = S_START;
          end
        end
      end
      S_START: begin
        cmd.scale_start = 1'b1;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale_step = 1'b1;
        if (sts.scale_done) state_next = S_FIX;
      end
      S_FIX: begin
        if (!out_valid) begin
          cmd.finish = 1'b1;
          out_valid_next = 1'b1;
          state_next = halt_after ? S_HALT : S_IDLE;
        end
      end
      S_HALT: state_next = S_HALT;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      halt_after <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      halt_after <= halt_after_next;
      out_valid <= out_valid_next;
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_one_cmd, 1'b1, $onehot0(cmd))
  `ASSERT_NEXT(a_finish_valid, cmd.finish, out_valid)
  `ASSERT_NEXT(a_halt_sticky, state == S_HALT, state == S_HALT)
endmodule
`default_nettype wire

// File: src/decimal_text_line_summer_top.sv
// top level of the decimal text line summer
// usage:
//   input channel in_valid/in_stall carries one text byte or end-of-text mark
//   output channel out_valid/out_stall carries running total and saturated flag
//   a byte that does not end a chunk is parsed and leaves the input ready
//   a chunk end passes the start state, the scaling loop and the fix state
//   after it is accepted, and the fix state raises its result request; the
//   loop multiplies by ten once per step going up until saturation, or
//   divides by ten in steps counted by dsub going down (at most 23 divisions
//   before the value reaches zero), then shifts up or checks the range
//   input is stalled while a chunk is scaled; a chunk end also waits until
//   the previous result request has been taken
//   a result stays on the port unchanged while out_stall is high
//   end of text flushes a nonempty chunk, then later requests are dropped
//   reset clears the sum, the chunk and the halt
`timescale 1ns / 1ps
`default_nettype none
module decimal_text_line_summer_top #(
  parameter int LINE_LIMIT = dtls_pkg::LineLimit,
  parameter int MANTISSA_DIGITS = dtls_pkg::MantissaDigits,
  parameter int FRACTION_BITS = dtls_pkg::FractionBits
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire dtls_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output dtls_pkg::out_t    out_data
);
  dtls_pkg::cmd_t cmd;
  dtls_pkg::sts_t sts;

  dtls_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .eot(in_data.end_of_text),
    .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
    .sts(sts), .cmd(cmd)
  );

  dtls_datapath #(
    .LINE_LIMIT(LINE_LIMIT), .MANTISSA_DIGITS(MANTISSA_DIGITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .ch(in_data.ch),
    .cmd(cmd), .sts(sts), .result(out_data)
  );
endmodule
`default_nettype wire
